// ===== design/framed_message_decoder_macros.svh =====
// Assertion macros used by the framed message decoder top level.
`ifndef FRAMED_MESSAGE_DECODER_MACROS_SVH
`define FRAMED_MESSAGE_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FMD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FMD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fmd_pkg.sv =====
// Types and constants for the framed message decoder.
`timescale 1ns / 1ps

package fmd_pkg;

    // Framing constants
    localparam logic [7:0] START_BYTE        = 8'hFA;
    localparam logic [7:0] MSG_STD           = 8'd1;
    localparam logic [7:0] MSG_MPC           = 8'd2;
    localparam logic [7:0] SEQ_WRAP_FROM     = 8'd254;
    localparam int         STD_PAYLOAD_BYTES = 13;
    localparam int         OBJ_STRIDE        = 9;

    // Configuration register indexes
    localparam logic [1:0] CFG_RPM_TARGET = 2'd0;
    localparam logic [1:0] CFG_DRIVE_MIN  = 2'd1;
    localparam logic [1:0] CFG_DRIVE_MAX  = 2'd2;

    // Configuration reset values
    localparam logic [7:0] RPM_TARGET_RST = 8'd125;
    localparam logic [6:0] DRIVE_MIN_RST  = 7'd30;
    localparam logic [6:0] DRIVE_MAX_RST  = 7'd70;
    localparam logic [7:0] LAST_RPM_RST   = 8'd125;

    // Field identifiers
    localparam logic [2:0] FID_X        = 3'd0;
    localparam logic [2:0] FID_RPM      = 3'd3;
    localparam logic [2:0] FID_TARGET_X = 3'd4;
    localparam logic [2:0] FID_PICKUP   = 3'd6;

    // Result kinds
    localparam logic RK_FIELD = 1'b0;
    localparam logic RK_DRIVE = 1'b1;

    // Request kinds
    localparam logic IK_BYTE = 1'b0;
    localparam logic IK_TICK = 1'b1;

    // Parser phases
    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_TYPE  = 4'b0010,
        PH_COUNT = 4'b0100,
        PH_BODY  = 4'b1000
    } fmd_phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } fmd_in_t;

    typedef struct packed {
        logic               result_kind;
        logic [2:0]         field_id;
        logic [1:0]         object_index;
        logic signed [31:0] field_value;
        logic               sequence_ok;
        logic               last_of_message;
        logic [6:0]         drive_level;
    } fmd_out_t;

    typedef struct packed {
        logic [7:0] rpm_target;
        logic [6:0] drive_min;
        logic [6:0] drive_max;
    } fmd_cfg_t;

    // Parser to top level / regulator
    typedef struct packed {
        logic        emit;
        logic [2:0]  field_id;
        logic [1:0]  obj;
        logic [31:0] value;
        logic        last;
        logic        seq_ok;
        logic        rpm_we;
        logic [7:0]  rpm;
    } fmd_field_t;

endpackage

// ===== design/fmd_parser.sv =====
// Frame parser: start byte hunt, header check, field assembly.
`timescale 1ns / 1ps

module fmd_parser
    import fmd_pkg::*;
#(
    parameter int MPC_PAYLOAD_BYTES = 36,
    parameter int MPC_OBJECTS       = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       go,
    input  logic [7:0] data_byte,
    output fmd_field_t fld
);

    fmd_phase_t  phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [5:0]  pos_reg, pos_next;
    logic [3:0]  off_reg, off_next;
    logic [1:0]  obj_reg, obj_next;
    logic [23:0] wa_reg, wa_next;
    logic [7:0]  cnt_reg [3];
    logic [7:0]  cnt_next [3];
    logic        flag_reg, flag_next;

    logic [7:0]  cnt_sel;
    logic [7:0]  cnt_expect;
    logic [6:0]  pos_inc;
    logic [1:0]  woff;
    logic        in_objs;

    // Expected count for the current type
    always_comb
    begin
        case (type_reg[1:0])
            2'd1:    cnt_sel = cnt_reg[1];
            2'd2:    cnt_sel = cnt_reg[2];
            default: cnt_sel = cnt_reg[0];
        endcase
        cnt_expect = (cnt_sel >= SEQ_WRAP_FROM) ? 8'd0 : cnt_sel + 8'd1;
    end

    assign pos_inc = {1'b0, pos_reg} + 7'd1;
    assign in_objs = obj_reg < 2'(MPC_OBJECTS);

    // Next state and emitted field
    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        pos_next   = pos_reg;
        off_next   = off_reg;
        obj_next   = obj_reg;
        wa_next    = wa_reg;
        flag_next  = flag_reg;
        for (int i = 0; i < 3; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        fld        = '0;
        fld.seq_ok = flag_reg;
        fld.rpm    = data_byte;
        woff       = 2'd0;

        if (go)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (data_byte == START_BYTE)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_next  = data_byte;
                    phase_next = PH_COUNT;
                end
                PH_COUNT:
                begin
                    // sequence check against the per-type counter
                    if (type_reg > MSG_MPC)
                    begin
                        flag_next = 1'b0;
                    end
                    else if (data_byte == cnt_expect)
                    begin
                        cnt_next[type_reg[1:0]] = data_byte;
                        flag_next               = 1'b1;
                    end
                    else
                    begin
                        flag_next = 1'b0;
                    end
                    pos_next = '0;
                    off_next = '0;
                    obj_next = '0;
                    wa_next  = '0;
                    if (type_reg == MSG_STD || type_reg == MSG_MPC)
                    begin
                        phase_next = PH_BODY;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_BODY:
                begin
                    pos_next = pos_inc[5:0];
                    if (type_reg == MSG_STD)
                    begin
                        // three words, then the rpm byte
                        if (pos_reg < 6'd12)
                        begin
                            woff = pos_reg[1:0];
                            if (woff == 2'd3)
                            begin
                                fld.emit     = 1'b1;
                                fld.field_id = {1'b0, pos_reg[3:2]};
                                fld.value    = {data_byte, wa_reg};
                            end
                        end
                        else if (pos_reg == 6'd12)
                        begin
                            fld.emit     = 1'b1;
                            fld.field_id = FID_RPM;
                            fld.value    = {24'd0, data_byte};
                            fld.last     = 1'b1;
                            fld.rpm_we   = 1'b1;
                        end
                        if (pos_inc >= 7'(STD_PAYLOAD_BYTES))
                        begin
                            phase_next = PH_HUNT;
                            pos_next   = '0;
                        end
                    end
                    else if (type_reg == MSG_MPC)
                    begin
                        // objects of two words and a pickup byte
                        if (in_objs)
                        begin
                            if (off_reg < 4'd8)
                            begin
                                woff = off_reg[1:0];
                                if (woff == 2'd3)
                                begin
                                    fld.emit     = 1'b1;
                                    fld.field_id = FID_TARGET_X + {2'd0, off_reg[2]};
                                    fld.obj      = obj_reg;
                                    fld.value    = {data_byte, wa_reg};
                                end
                            end
                            else
                            begin
                                fld.emit     = 1'b1;
                                fld.field_id = FID_PICKUP;
                                fld.obj      = obj_reg;
                                fld.value    = {24'd0, data_byte};
                                fld.last     = (obj_reg == 2'(MPC_OBJECTS - 1));
                            end
                        end
                        if (off_reg == 4'(OBJ_STRIDE - 1))
                        begin
                            off_next = '0;
                            if (in_objs)
                            begin
                                obj_next = obj_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            off_next = off_reg + 4'd1;
                        end
                        if (pos_inc >= 7'(MPC_PAYLOAD_BYTES))
                        begin
                            phase_next = PH_HUNT;
                            pos_next   = '0;
                        end
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end

                    // word assembly for the word bytes of either type
                    if ((type_reg == MSG_STD && pos_reg < 6'd12) ||
                        (type_reg == MSG_MPC && in_objs && off_reg < 4'd8))
                    begin
                        case (woff)
                            2'd0:    wa_next = {16'd0, data_byte};
                            2'd1:    wa_next = wa_reg | {8'd0, data_byte, 8'd0};
                            2'd2:    wa_next = wa_reg | {data_byte, 16'd0};
                            default: wa_next = wa_reg;
                        endcase
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            type_reg  <= '0;
            pos_reg   <= '0;
            off_reg   <= '0;
            obj_reg   <= '0;
            wa_reg    <= '0;
            flag_reg  <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            pos_reg   <= pos_next;
            off_reg   <= off_next;
            obj_reg   <= obj_next;
            wa_reg    <= wa_next;
            flag_reg  <= flag_next;
            for (int i = 0; i < 3; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

endmodule

// ===== design/fmd_regulator.sv =====
// Lidar motor drive regulator: nudges drive toward target rpm on each tick.
`timescale 1ns / 1ps

module fmd_regulator
    import fmd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick,
    input  logic       rpm_we,
    input  logic [7:0] rpm,
    input  fmd_cfg_t   cfg,
    output logic [6:0] drive,
    output logic [6:0] drive_new
);

    logic [7:0]        last_rpm_reg, last_rpm_next;
    logic [6:0]        drive_reg, drive_next;
    logic signed [8:0] d_step;

    // One step toward the target unless the last rpm is zero, then clamp (upper limit first)
    always_comb
    begin
        d_step = signed'({2'b00, drive_reg});
        if (last_rpm_reg != 8'd0)
        begin
            if (last_rpm_reg > cfg.rpm_target)
            begin
                d_step = d_step - 9'sd1;
            end
            else if (last_rpm_reg < cfg.rpm_target)
            begin
                d_step = d_step + 9'sd1;
            end
        end
        if (d_step > signed'({2'b00, cfg.drive_max}))
        begin
            drive_new = cfg.drive_max;
        end
        else if (d_step < signed'({2'b00, cfg.drive_min}))
        begin
            drive_new = cfg.drive_min;
        end
        else
        begin
            drive_new = d_step[6:0];
        end
    end

    assign drive_next    = tick ? drive_new : drive_reg;
    assign last_rpm_next = rpm_we ? rpm : last_rpm_reg;
    assign drive         = drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg    <= '0;
            last_rpm_reg <= LAST_RPM_RST;
        end
        else
        begin
            drive_reg    <= drive_next;
            last_rpm_reg <= last_rpm_next;
        end
    end

endmodule

// ===== design/framed_message_decoder.sv =====
// Framed message decoder top level: request register, parser, regulator, result register.
//
// Requests arrive on item/item_valid/item_ready: kind 0 carries one received
// UART byte, kind 1 is a regulator period tick. Results leave on
// result/result_valid/result_ready: a decoded field (x, y, theta, rpm, or a
// target object's x, y, pickup) or, for every tick, the new drive level.
// Header bytes and ignored bytes give no result.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 rpm target,
// 1 drive minimum, 2 drive maximum) in the same cycle; other indexes are ignored.
// A taken request waits in the request register until the result register is free
// or its result is leaving; then the parse/regulate logic handles it and loads any
// result into the result register. Throughput: one request per cycle while results
// are taken.
// A stalled receiver holds the result register; the request register still
// takes one more request, after which item_ready drops until the result leaves.
// Reset: parser hunts for the start byte, counters cleared, drive 0, last rpm
// 125, registers at 125 / 30 / 70.
`timescale 1ns / 1ps
`include "framed_message_decoder_macros.svh"

module framed_message_decoder
    import fmd_pkg::*;
#(
    parameter int MPC_PAYLOAD_BYTES = 36,
    parameter int MPC_OBJECTS       = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  fmd_in_t    item,
    output logic       result_valid,
    input  logic       result_ready,
    output fmd_out_t   result,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic       s_valid_reg, s_valid_next;
    fmd_in_t    s_item_reg, s_item_next;
    logic       r_valid_reg, r_valid_next;
    fmd_out_t   r_data_reg, r_data_next;
    fmd_cfg_t   cfg_reg, cfg_next;
    logic       proc_go;
    logic       byte_go;
    logic       tick_go;
    fmd_field_t fld;
    logic [6:0] drive;
    logic [6:0] drive_new;

    // Handshake
    assign proc_go    = s_valid_reg && (!r_valid_reg || result_ready);
    assign item_ready = !s_valid_reg || proc_go;
    assign byte_go    = proc_go && (s_item_reg.kind == IK_BYTE);
    assign tick_go    = proc_go && (s_item_reg.kind == IK_TICK);

    // Configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_RPM_TARGET: cfg_next.rpm_target = cfg_data;
                CFG_DRIVE_MIN:  cfg_next.drive_min  = cfg_data[6:0];
                CFG_DRIVE_MAX:  cfg_next.drive_max  = cfg_data[6:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    fmd_parser #(
        .MPC_PAYLOAD_BYTES (MPC_PAYLOAD_BYTES),
        .MPC_OBJECTS       (MPC_OBJECTS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (byte_go),
        .data_byte (s_item_reg.data_byte),
        .fld       (fld)
    );

    fmd_regulator u_regulator (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_go),
        .rpm_we    (byte_go && fld.rpm_we),
        .rpm       (fld.rpm),
        .cfg       (cfg_reg),
        .drive     (drive),
        .drive_new (drive_new)
    );

    // Request register
    always_comb
    begin
        s_valid_next = s_valid_reg;
        s_item_next  = s_item_reg;
        if (item_valid && item_ready)
        begin
            s_valid_next = 1'b1;
            s_item_next  = item;
        end
        else if (proc_go)
        begin
            s_valid_next = 1'b0;
        end
    end

    // Result register
    always_comb
    begin
        r_valid_next = r_valid_reg;
        r_data_next  = r_data_reg;
        if (r_valid_reg && result_ready)
        begin
            r_valid_next = 1'b0;
        end
        if (tick_go)
        begin
            r_valid_next                = 1'b1;
            r_data_next                 = '0;
            r_data_next.result_kind     = RK_DRIVE;
            r_data_next.drive_level     = drive_new;
        end
        else if (byte_go && fld.emit)
        begin
            r_valid_next                = 1'b1;
            r_data_next.result_kind     = RK_FIELD;
            r_data_next.field_id        = fld.field_id;
            r_data_next.object_index    = fld.obj;
            r_data_next.field_value     = signed'(fld.value);
            r_data_next.sequence_ok     = fld.seq_ok;
            r_data_next.last_of_message = fld.last;
            r_data_next.drive_level     = drive;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg        <= 1'b0;
            r_valid_reg        <= 1'b0;
            cfg_reg.rpm_target <= RPM_TARGET_RST;
            cfg_reg.drive_min  <= DRIVE_MIN_RST;
            cfg_reg.drive_max  <= DRIVE_MAX_RST;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            r_valid_reg <= r_valid_next;
            cfg_reg     <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_item_reg <= s_item_next;
        r_data_reg <= r_data_next;
    end

    assign result_valid = r_valid_reg;
    assign result       = r_data_reg;

    // Checks
    `FMD_ASSERT_NEXT(a_req_held, s_valid_reg && !proc_go, s_valid_reg,
        "pending request dropped")
    `FMD_ASSERT_NEXT(a_tick_result, tick_go,
        result_valid && result.result_kind == RK_DRIVE,
        "tick produced no drive result")
    `FMD_ASSERT_NOW(a_last_field, result_valid && result.result_kind == RK_FIELD &&
        result.last_of_message,
        result.field_id == FID_RPM || result.field_id == FID_PICKUP,
        "end of message on a word field")
    `FMD_ASSERT_NOW(a_drive_range, result_valid && result.result_kind == RK_DRIVE &&
        cfg_reg.drive_min <= cfg_reg.drive_max,
        result.drive_level >= cfg_reg.drive_min &&
        result.drive_level <= cfg_reg.drive_max,
        "drive level outside limits")

endmodule

// ===== sim/tb_framed_message_decoder.sv =====
// Testbench for the framed message decoder: directed table, then predictor-checked random traffic.
`timescale 1ns / 1ps

module tb_framed_message_decoder;
    import fmd_pkg::*;

    localparam int         MPC_BYTES    = 36;
    localparam int         MPC_OBJ      = 3;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         QUIET_LIMIT  = 2000;
    localparam int         MAX_REPORTS  = 10;
    localparam logic [7:0] MSG_NULL     = 8'd0;
    localparam logic [2:0] FID_Y        = 3'd1;
    localparam logic [1:0] CFG_UNUSED   = 2'd3;

    typedef struct {
        fmd_in_t  req;
        bit       typed;
        fmd_out_t want;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    fmd_in_t    item;
    logic       result_valid;
    logic       result_ready;
    fmd_out_t   result;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    // Register mirror
    logic [7:0] cfg_rpm_target = RPM_TARGET_RST;
    logic [6:0] cfg_drive_min  = DRIVE_MIN_RST;
    logic [6:0] cfg_drive_max  = DRIVE_MAX_RST;

    // Decoder and regulator mirror
    fmd_phase_t  prs_phase  = PH_HUNT;
    logic [7:0]  msg_type   = '0;
    logic [5:0]  body_pos   = '0;
    logic [23:0] word_acc   = '0;
    logic [7:0]  seq_cnt [3] = '{default: 8'd0};
    logic        seq_good   = 1'b0;
    logic [7:0]  rpm_seen   = LAST_RPM_RST;
    logic [6:0]  drive_now  = '0;

    fmd_out_t   pending [$];
    logic [7:0] frame_buf [$];
    dir_row_t   dir_tab [$];
    int         miss_count   = 0;
    int         quiet_cycles = 0;
    int         stall_left   = 0;
    bit         idle_on      = 1'b1;

    framed_message_decoder #(
        .MPC_PAYLOAD_BYTES(MPC_BYTES),
        .MPC_OBJECTS      (MPC_OBJ)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic fmd_in_t mk_req(logic k, logic [7:0] b);
        fmd_in_t r;
        r.kind      = k;
        r.data_byte = b;
        return r;
    endfunction

    function automatic fmd_out_t field_res(logic [2:0] id, logic [1:0] obj, logic [31:0] val,
                                           logic ok, logic last, logic [6:0] drv);
        fmd_out_t r;
        r.result_kind     = RK_FIELD;
        r.field_id        = id;
        r.object_index    = obj;
        r.field_value     = val;
        r.sequence_ok     = ok;
        r.last_of_message = last;
        r.drive_level     = drv;
        return r;
    endfunction

    function automatic fmd_out_t drive_res(logic [6:0] lvl);
        fmd_out_t r;
        r             = '0;
        r.result_kind = RK_DRIVE;
        r.drive_level = lvl;
        return r;
    endfunction

    function automatic dir_row_t dir_row(logic k, logic [7:0] b, bit typed, fmd_out_t want);
        dir_row_t r;
        r.req   = mk_req(k, b);
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    // Count the header must carry for the next message of type t
    function automatic logic [7:0] next_count(int t);
        return (seq_cnt[t] >= SEQ_WRAP_FROM) ? 8'd0 : seq_cnt[t] + 8'd1;
    endfunction

    // Little-endian word assembly; true once the top byte is in
    function automatic bit word_gather(input logic [1:0] off, input logic [7:0] b,
                                       output logic [31:0] val);
        val = '0;
        if (off == 2'd0)
        begin
            word_acc = {16'h0, b};
            return 1'b0;
        end
        if (off != 2'd3)
        begin
            word_acc = word_acc | (24'(b) << (8 * off));
            return 1'b0;
        end
        val = {b, word_acc};
        return 1'b1;
    endfunction

    // One accepted request through the decoder/regulator mirror
    task automatic decode_step(input fmd_in_t req, output bit hit, output fmd_out_t res);
        int          d;
        int          pos;
        int          obj;
        int          off;
        logic [31:0] val;
        logic [7:0]  b;
        b   = req.data_byte;
        hit = 1'b0;
        res = '0;
        if (req.kind == IK_TICK)
        begin
            // nudge toward target, upper limit checked first
            d = int'(drive_now);
            if (rpm_seen != 8'd0)
            begin
                if (rpm_seen > cfg_rpm_target)
                    d -= 1;
                else if (rpm_seen < cfg_rpm_target)
                    d += 1;
            end
            if (d > int'(cfg_drive_max))
                d = int'(cfg_drive_max);
            else if (d < int'(cfg_drive_min))
                d = int'(cfg_drive_min);
            drive_now = 7'(d);
            hit = 1'b1;
            res = drive_res(drive_now);
        end
        else
        begin
            case (prs_phase)
                PH_HUNT:
                begin
                    if (b == START_BYTE)
                        prs_phase = PH_TYPE;
                end
                PH_TYPE:
                begin
                    msg_type  = b;
                    prs_phase = PH_COUNT;
                end
                PH_COUNT:
                begin
                    if (msg_type > MSG_MPC)
                        seq_good = 1'b0;
                    else if (b == next_count(int'(msg_type)))
                    begin
                        seq_cnt[msg_type[1:0]] = b;
                        seq_good = 1'b1;
                    end
                    else
                        seq_good = 1'b0;
                    body_pos = '0;
                    word_acc = '0;
                    if (msg_type == MSG_STD || msg_type == MSG_MPC)
                        prs_phase = PH_BODY;
                    else
                        prs_phase = PH_HUNT;
                end
                default:
                begin
                    pos      = int'(body_pos);
                    body_pos = 6'(pos + 1);
                    if (msg_type == MSG_STD)
                    begin
                        // x, y, theta words then the rpm byte
                        if (pos < 12)
                        begin
                            if (word_gather(2'(pos), b, val))
                            begin
                                hit = 1'b1;
                                res = field_res(3'(pos >> 2), 2'd0, val, seq_good, 1'b0,
                                                drive_now);
                            end
                        end
                        else if (pos == 12)
                        begin
                            rpm_seen = b;
                            hit = 1'b1;
                            res = field_res(FID_RPM, 2'd0, {24'h0, b}, seq_good, 1'b1,
                                            drive_now);
                        end
                        if (pos + 1 >= STD_PAYLOAD_BYTES)
                        begin
                            prs_phase = PH_HUNT;
                            body_pos  = '0;
                        end
                    end
                    else if (msg_type == MSG_MPC)
                    begin
                        // objects of x word, y word, pickup byte; tail ignored
                        obj = pos / OBJ_STRIDE;
                        off = pos % OBJ_STRIDE;
                        if (obj < MPC_OBJ)
                        begin
                            if (off < 8)
                            begin
                                if (word_gather(2'(off), b, val))
                                begin
                                    hit = 1'b1;
                                    res = field_res(FID_TARGET_X + 3'(off >> 2), 2'(obj), val,
                                                    seq_good, 1'b0, drive_now);
                                end
                            end
                            else
                            begin
                                hit = 1'b1;
                                res = field_res(FID_PICKUP, 2'(obj), {24'h0, b}, seq_good,
                                                (obj + 1 == MPC_OBJ), drive_now);
                            end
                        end
                        if (pos + 1 >= MPC_BYTES)
                        begin
                            prs_phase = PH_HUNT;
                            body_pos  = '0;
                        end
                    end
                    else
                        prs_phase = PH_HUNT;
                end
            endcase
        end
    endtask

    // Drive one request and log what it should produce
    task automatic send_req(input fmd_in_t req, input bit typed, input fmd_out_t want);
        bit       hit;
        fmd_out_t res;
        if (idle_on && $urandom_range(99) < 20)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= req;
        do
            @(posedge clk);
        while (!item_ready);
        decode_step(req, hit, res);
        if (typed)
            pending.push_back(want);
        else if (hit)
            pending.push_back(res);
    endtask

    task automatic send_tick();
        send_req(mk_req(IK_TICK, 8'($urandom_range(255))), 1'b0, '0);
    endtask

    // Send the buffered frame bytes, ticks sprinkled in between
    task automatic send_frame(input int tick_pct);
        foreach (frame_buf[i])
        begin
            if ($urandom_range(99) < tick_pct)
                send_tick();
            send_req(mk_req(IK_BYTE, frame_buf[i]), 1'b0, '0);
        end
        frame_buf.delete();
    endtask

    task automatic push_std(input logic [7:0] rpm);
        frame_buf.push_back(START_BYTE);
        frame_buf.push_back(MSG_STD);
        frame_buf.push_back(next_count(1));
        repeat (STD_PAYLOAD_BYTES - 1) frame_buf.push_back(8'($urandom_range(255)));
        frame_buf.push_back(rpm);
    endtask

    task automatic push_mpc();
        frame_buf.push_back(START_BYTE);
        frame_buf.push_back(MSG_MPC);
        frame_buf.push_back(next_count(2));
        repeat (MPC_BYTES) frame_buf.push_back(8'($urandom_range(255)));
    endtask

    // Mostly well-formed messages; the rest noise and broken frames
    task automatic random_messages(input int n, input int tick_pct);
        int pick;
        int keep;
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                push_std(($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255)));
            else if (pick < 60)
                push_mpc();
            else if (pick < 70)
            begin
                // wrong sequence count
                if (pick[0])
                    push_std(8'($urandom_range(255)));
                else
                    push_mpc();
                frame_buf[2] = 8'($urandom_range(255));
            end
            else if (pick < 78)
            begin
                frame_buf.push_back(START_BYTE);
                frame_buf.push_back(MSG_NULL);
                frame_buf.push_back(pick[0] ? next_count(0) : 8'($urandom_range(255)));
            end
            else if (pick < 85)
            begin
                frame_buf.push_back(START_BYTE);
                frame_buf.push_back(8'($urandom_range(255, 3)));
                frame_buf.push_back(8'($urandom_range(255)));
            end
            else if (pick < 93)
                repeat ($urandom_range(6, 1)) frame_buf.push_back(8'($urandom_range(255)));
            else
            begin
                // cut short; the next frame lands in this body
                if (pick[0])
                    push_std(8'($urandom_range(255)));
                else
                    push_mpc();
                keep = $urandom_range(frame_buf.size() - 1, 3);
                while (frame_buf.size() > keep)
                    void'(frame_buf.pop_back());
            end
            send_frame(tick_pct);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_RPM_TARGET: cfg_rpm_target = val;
            CFG_DRIVE_MIN:  cfg_drive_min  = val[6:0];
            CFG_DRIVE_MAX:  cfg_drive_max  = val[6:0];
            default: ;
        endcase
    endtask

    task automatic program_settings(input logic [7:0] tgt, input logic [7:0] lo,
                                    input logic [7:0] hi);
        write_reg(CFG_UNUSED, 8'($urandom_range(255)));
        write_reg(CFG_RPM_TARGET, tgt);
        write_reg(CFG_DRIVE_MIN, lo);
        write_reg(CFG_DRIVE_MAX, hi);
        cfg_we <= 1'b0;
    endtask

    // Wait for every result, then let the pipeline drain
    task automatic settle_block();
        item_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result checker and receiver stalls
    always @(posedge clk)
    begin : result_monitor
        fmd_out_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (pending.size() == 0)
                begin
                    miss_count++;
                    if (miss_count <= MAX_REPORTS)
                    begin
                        $display("unexpected result: kind %0d id %0d obj %0d val %h",
                                 result.result_kind, result.field_id, result.object_index,
                                 result.field_value);
                        $display("    ok %0d last %0d drv %0d",
                                 result.sequence_ok, result.last_of_message,
                                 result.drive_level);
                    end
                end
                else
                begin
                    want = pending.pop_front();
                    if (result.result_kind !== want.result_kind ||
                        result.field_id !== want.field_id ||
                        result.object_index !== want.object_index ||
                        result.field_value !== want.field_value ||
                        result.sequence_ok !== want.sequence_ok ||
                        result.last_of_message !== want.last_of_message ||
                        result.drive_level !== want.drive_level)
                    begin
                        miss_count++;
                        if (miss_count <= MAX_REPORTS)
                        begin
                            $display({"mismatch: exp kind %0d id %0d obj %0d val %h",
                                      " ok %0d last %0d drv %0d"},
                                     want.result_kind, want.field_id, want.object_index,
                                     want.field_value, want.sequence_ok, want.last_of_message,
                                     want.drive_level);
                            $display({"          got kind %0d id %0d obj %0d val %h",
                                      " ok %0d last %0d drv %0d"},
                                     result.result_kind, result.field_id,
                                     result.object_index, result.field_value,
                                     result.sequence_ok, result.last_of_message,
                                     result.drive_level);
                        end
                    end
                end
            end
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else if (idle_on && $urandom_range(99) < 15)
            begin
                result_ready <= 1'b0;
                stall_left   <= $urandom_range(4, 0);
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Cycles with no request or result moving
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        item_valid <= 1'b0;
        item       <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        rst_n      <= 1'b0;

        // Directed: reset drive, word extremes, tick mid-message, zero rpm, odd types
        dir_tab.push_back(dir_row(IK_TICK, 8'h00, 1'b1, drive_res(DRIVE_MIN_RST)));
        dir_tab.push_back(dir_row(IK_BYTE, 8'h00, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, START_BYTE, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, MSG_STD, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, 8'h01, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, 8'hFF, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, 8'hFF, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, 8'hFF, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, 8'h7F, 1'b1,
                          field_res(FID_X, 2'd0, 32'h7FFF_FFFF, 1'b1, 1'b0, DRIVE_MIN_RST)));
        dir_tab.push_back(dir_row(IK_BYTE, 8'h00, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, 8'h00, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_TICK, 8'hFF, 1'b1, drive_res(DRIVE_MIN_RST)));
        dir_tab.push_back(dir_row(IK_BYTE, 8'h00, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, 8'h80, 1'b1,
                          field_res(FID_Y, 2'd0, 32'h8000_0000, 1'b1, 1'b0, DRIVE_MIN_RST)));
        dir_tab.push_back(dir_row(IK_BYTE, 8'h78, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, 8'h56, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, 8'h34, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, 8'h12, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, 8'h00, 1'b1,
                          field_res(FID_RPM, 2'd0, 32'h0, 1'b1, 1'b1, DRIVE_MIN_RST)));
        dir_tab.push_back(dir_row(IK_TICK, 8'h00, 1'b1, drive_res(DRIVE_MIN_RST)));
        dir_tab.push_back(dir_row(IK_BYTE, START_BYTE, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, 8'h03, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, 8'h00, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, START_BYTE, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, MSG_NULL, 1'b0, '0));
        dir_tab.push_back(dir_row(IK_BYTE, 8'h01, 1'b0, '0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
        random_messages(3, 25);

        // Drive pushed to the top while the type-0 counter runs past its wrap
        settle_block();
        program_settings(8'd255, 8'd120, 8'd127);
        push_std(8'd100);
        send_frame(0);
        for (int k = 0; k < 256; k++)
        begin
            frame_buf.push_back(START_BYTE);
            frame_buf.push_back(MSG_NULL);
            frame_buf.push_back(next_count(0));
            send_frame(3);
        end

        // Full range, target zero: ramp down to the floor
        settle_block();
        program_settings(8'd0, 8'd0, 8'd127);
        push_std(8'd200);
        send_frame(0);
        repeat (140) send_tick();

        // Minimum above maximum
        settle_block();
        program_settings(8'd255, 8'd127, 8'd0);
        random_messages(2, 25);

        settle_block();
        program_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));
        random_messages(2, 30);

        // Last part runs with no idling
        settle_block();
        idle_on = 1'b0;
        program_settings(RPM_TARGET_RST, 8'd64, 8'd64);
        random_messages(2, 25);

        settle_block();
        program_settings(8'($urandom_range(255)), 8'($urandom_range(40)),
                         8'($urandom_range(127, 60)));
        random_messages(2, 25);

        settle_block();
        if (miss_count == 0 && pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
